// ===== rtl/ibo_pkg.sv =====
// Shared constants, types and the face-centre table of the observability unit.
// No dependencies; used by ibo_locate and icosahedral_boundary_observability_unit.
`default_nettype none
package ibo_pkg;

  localparam int NUM_BINS        = 20;
  localparam int BIN_W           = $clog2(NUM_BINS);
  localparam int COORD_WIDTH_DEF = 16;
  localparam int K_W             = 8;
  localparam int AW_W            = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CNT_W           = 9;
  localparam int VOL_W           = 30;
  localparam int TOT_W           = 34;
  localparam int QV_W            = 17;
  localparam int N_W             = 26;
  localparam int M_W             = ((TOT_W + QV_W + 7) / 8) * 8;
  localparam int VOL_COEFF_W     = 30;
  localparam int VOL_SHIFT       = 48;
  localparam int FRAC_SHIFT      = 16;

  localparam logic [31:0]     VOL_COEFF = 32'd899535847;
  localparam logic [QV_W-1:0] QV_FULL   = 17'h10000;
  localparam logic [K_W-1:0]  K_RESET   = 8'd4;
  localparam logic [AW_W-1:0] AW_RESET  = 16'd32768;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CONF_STEPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMB_WIDTH  = 1'b1;

  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] bin;
  } loc_stat_t;

  localparam logic signed [15:0] FA = 16'sd26039;
  localparam logic signed [15:0] FB = 16'sd6147;
  localparam logic signed [15:0] FC = 16'sd16093;
  localparam logic signed [15:0] FD = 16'sd19892;
  localparam logic signed [15:0] FE = 16'sd32186;
  localparam logic signed [15:0] FF = 16'sd9946;
  localparam logic signed [15:0] FG = 16'sd18919;
  localparam logic signed [15:0] FH = 16'sd11692;
  localparam logic signed [15:0] FI = 16'sd30611;
  localparam logic signed [15:0] F0 = 16'sd0;

  // face centres in Q1.15, one row per bin: x, y, z
  localparam logic signed [15:0] CENTRE [NUM_BINS][3] = '{
    '{-FB, FA, -FG}, '{FC, FA, FH},   '{-FD, FA, F0}, '{FC, FA, -FH},
    '{-FB, FA, FG},  '{-FE, FB, F0},  '{-FF, FB, FI}, '{FA, FB, -FG},
    '{-FF, FB, -FI}, '{FA, FB, FG},   '{-FA, -FB, -FG}, '{FF, -FB, FI},
    '{-FA, -FB, FG}, '{FF, -FB, -FI}, '{FE, -FB, F0}, '{FB, -FA, -FG},
    '{FD, -FA, F0},  '{-FC, -FA, FH}, '{-FC, -FA, -FH}, '{FB, -FA, FG}
  };

  function automatic logic signed [15:0] centre_val(input logic [BIN_W-1:0] j,
                                                    input logic [1:0] c);
    logic signed [15:0] v;
    v = F0;
    if (int'(j) < NUM_BINS && c != 2'd3) begin
      v = CENTRE[j][c];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ibo_locate.sv =====
// Radius and bin finder: bit-serial square root and a 20-way argmax over one signed MAC.
// Depends on ibo_pkg.
`default_nettype none
module ibo_locate #(
  parameter int COORD_WIDTH = ibo_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [COORD_WIDTH-1:0] x,
  input  wire logic signed [COORD_WIDTH-1:0] y,
  input  wire logic signed [COORD_WIDTH-1:0] z,
  output logic             [COORD_WIDTH-1:0] radius,
  output ibo_pkg::loc_stat_t                 stat
);

  localparam int CW    = COORD_WIDTH;
  localparam int MB_W  = (CW > 16) ? CW : 16;
  localparam int P_W   = CW + MB_W;
  localparam int ACC_W = ((2 * CW > CW + 16) ? 2 * CW : CW + 16) + 1;
  localparam int GRP_W = $clog2(ibo_pkg::NUM_BINS + 1);
  localparam int RAD_W = 2 * CW;
  localparam int REM_W = CW + 3;
  localparam int SQC_W = $clog2(CW + 1);

  logic                          iss;
  logic [GRP_W-1:0]              grp;
  logic [1:0]                    crd;
  logic                          vld_d;
  logic [GRP_W-1:0]              grp_d;
  logic [1:0]                    crd_d;
  logic signed [P_W-1:0]         prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       top_score;
  logic signed [ACC_W-1:0]       sum_now;
  logic signed [CW-1:0]          coord;
  logic signed [MB_W-1:0]        bop;
  logic [RAD_W-1:0]              rad;
  logic [REM_W-1:0]              rem;
  logic [REM_W-1:0]              rem_t;
  logic [REM_W-1:0]              trial;
  logic [SQC_W-1:0]              sq_cnt;

  always_comb begin
    unique case (crd)
      2'd0:    coord = x;
      2'd1:    coord = y;
      default: coord = z;
    endcase
    if (grp == '0) begin
      bop = MB_W'(coord);
    end else begin
      bop = MB_W'(ibo_pkg::centre_val(ibo_pkg::BIN_W'(grp - GRP_W'(1)), crd));
    end
    sum_now = ((crd_d == 2'd0) ? '0 : acc) + ACC_W'(prod);
    rem_t   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial   = REM_W'({radius, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss       <= 1'b0;
      vld_d     <= 1'b0;
      stat.done <= 1'b0;
      sq_cnt    <= '0;
    end else begin
      // issue one product per cycle: three squares, then three per bin
      vld_d <= iss;
      grp_d <= grp;
      crd_d <= crd;
      prod  <= coord * bop;
      if (start) begin
        iss <= 1'b1;
        grp <= '0;
        crd <= '0;
      end else if (iss) begin
        if (crd == 2'd2) begin
          crd <= '0;
          grp <= grp + GRP_W'(1);
          if (grp == GRP_W'(ibo_pkg::NUM_BINS)) begin
            iss <= 1'b0;
          end
        end else begin
          crd <= crd + 2'd1;
        end
      end

      stat.done <= vld_d && crd_d == 2'd2 && grp_d == GRP_W'(ibo_pkg::NUM_BINS);
      if (vld_d) begin
        acc <= sum_now;
        if (crd_d == 2'd2) begin
          if (grp_d == '0) begin
            rad    <= RAD_W'(sum_now);
            rem    <= '0;
            radius <= '0;
            sq_cnt <= SQC_W'(CW);
          end else if (grp_d == GRP_W'(1) || sum_now > top_score) begin
            // strict compare keeps the lowest index on ties
            top_score <= sum_now;
            stat.bin  <= ibo_pkg::BIN_W'(grp_d - GRP_W'(1));
          end
        end
      end

      // one root bit per cycle
      if (sq_cnt != '0) begin
        sq_cnt <= sq_cnt - SQC_W'(1);
        rad    <= {rad[RAD_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem    <= rem_t - trial;
          radius <= {radius[CW-2:0], 1'b1};
        end else begin
          rem    <= rem_t;
          radius <= {radius[CW-2:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/icosahedral_boundary_observability_unit.sv =====
// Top level of the icosahedral boundary observability unit: bin memory, volume sequencer.
// Depends on ibo_pkg and ibo_locate.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready. s_tuser carries the opcode (0 update,
//   1 query); s_tdata carries pos_x, pos_y, pos_z and the seen flag. Every input
//   beat yields exactly one output beat on m_tvalid/m_tready carrying the running
//   total observability and the query value (zero for updates).
//   Items are handled one at a time. Each item first passes the locate stage (start,
//   three squares plus 60 dot-product terms through one registered multiplier, then
//   the done flag). A query or an update that leaves its bin untouched then passes
//   through ST_EVAL and ST_FIN to the output register. A query in the ambiguous
//   band adds two multiplies and a bit-serial divide. An update that changes a bin
//   adds one or two cube computations and, when both are needed, the weighting
//   multiplies and the divide. The worst-case spacing of input beats is set by the
//   shared multiplier and the one-bit-per-cycle divider.
//   Reset restores the registers to k=4, w=32768 and clears the bins through
//   per-bin valid flags, so no clearing pass is needed. Writing k reloads every
//   ambiguity counter the same way. Configure only while idle.
//   The result sits in an output register; a stalled receiver holds the next item
//   at its last step until the register frees, and no new input is taken meanwhile.
`default_nettype none
module icosahedral_boundary_observability_unit #(
  parameter int COORD_WIDTH = ibo_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // pos_x, pos_y, pos_z, seen, zero fill
  input  wire logic [((3*COORD_WIDTH+8)/8)*8-1:0]  s_tdata,
  // opcode
  input  wire logic                                 s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // total_observability, query_value, zero fill
  output logic [ibo_pkg::M_W-1:0]                   m_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [ibo_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [ibo_pkg::CFG_W-1:0]            cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int NU_W  = CW + 1;
  localparam int VW    = 3 * CW + ibo_pkg::VOL_COEFF_W - ibo_pkg::VOL_SHIFT;
  localparam int MA_W  = 3 * CW;
  localparam int NCH   = (MA_W + 31) / 32;
  localparam int MAP_W = NCH * 32;
  localparam int MR_W  = MAP_W + 32;
  localparam int MC_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DV_W  = VW + 10;
  localparam int DC_W  = $clog2(DV_W + 1);
  localparam int NB    = ibo_pkg::NUM_BINS;
  localparam int BW    = ibo_pkg::BIN_W;
  localparam int CNW   = ibo_pkg::CNT_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOC  = 9'b000000010,
    ST_EVAL = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_MULW = 9'b000010000,
    ST_POST = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_WB   = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    OP_R2, OP_R3, OP_V, OP_N1, OP_N2, OP_SN
  } op_t;

  typedef struct packed {
    logic [CW-1:0]            fs;
    logic [NU_W-1:0]          nu;
    logic [CNW-1:0]           cnt;
    logic [ibo_pkg::VOL_W-1:0] vol;
  } ent_t;

  state_t state;
  op_t    op;

  // configuration and running state
  logic [ibo_pkg::K_W-1:0]   k;
  logic [ibo_pkg::AW_W-1:0]  w;
  logic [ibo_pkg::TOT_W-1:0] total;
  logic [NB-1:0]             ent_vld;
  logic [NB-1:0]             cnt_vld;

  // bin memory
  ent_t    mem [NB];
  ent_t    rd;
  ent_t    wd;
  logic    mem_we;
  logic    mem_re;
  logic    ev;
  logic    cv;

  // item
  logic                 opc;
  logic                 seen;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] pz;
  logic                 loc_start;
  logic [CW-1:0]        r;
  logic [CW-1:0]        loc_r;
  logic [BW-1:0]        bin;
  ibo_pkg::loc_stat_t   loc_stat;

  // working values
  logic [CW-1:0]             fs_w;
  logic [NU_W-1:0]           nu_w;
  logic [CNW-1:0]            cnt_w;
  logic [ibo_pkg::VOL_W-1:0] ovol;
  logic [ibo_pkg::VOL_W-1:0] nv;
  logic                      split;
  logic                      vph;
  logic [VW-1:0]             s1;
  logic [VW-1:0]             vf;
  logic [ibo_pkg::N_W-1:0]   n;
  logic [ibo_pkg::QV_W-1:0]  qv;

  // multiplier
  logic [MA_W-1:0]  ma;
  logic [MAP_W-1:0] ma_pad;
  logic [31:0]      mb;
  logic [MC_W-1:0]  mc;
  logic [63:0]      pp;
  logic             pp_vld;
  logic [MR_W-1:0]  macc;
  logic [VW-1:0]    vres;
  logic [ibo_pkg::N_W-1:0] nsum;

  // divider
  logic [DV_W-1:0]  quo;
  logic [CNW:0]     drem;
  logic [CNW:0]     dtrial;
  logic [CNW-1:0]   den;
  logic [DC_W-1:0]  dc;
  logic [VW:0]      nv_sum;

  // evaluation of the fetched bin
  logic [CW-1:0]   f_fs;
  logic [NU_W-1:0] f_nu;
  logic [CNW-1:0]  f_cnt;
  logic [CNW-1:0]  lim;
  logic [CW-1:0]   fs_n;
  logic [NU_W-1:0] nu_n;
  logic [CNW-1:0]  cnt_n;
  logic            u1;
  logic            inb;

  ibo_locate #(.COORD_WIDTH(CW)) u_locate (
    .clk    (clk),
    .rst    (rst),
    .start  (loc_start),
    .x      (px),
    .y      (py),
    .z      (pz),
    .radius (loc_r),
    .stat   (loc_stat)
  );

  assign s_tready  = (state == ST_IDLE);
  assign loc_start = (state == ST_LOC) && !loc_stat.done && (op == OP_R2) && !pp_vld;
  assign mem_re    = (state == ST_LOC) && loc_stat.done;
  assign mem_we    = (state == ST_WB);
  assign wd        = '{fs: fs_w, nu: nu_w, cnt: cnt_w, vol: nv};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bin] <= wd;
    end
    if (mem_re) begin
      rd <= mem[loc_stat.bin];
    end
  end

  always_comb begin
    // an entry never written reads as its reset value
    f_fs  = ev ? rd.fs : '0;
    f_nu  = ev ? rd.nu : '1;
    f_cnt = cv ? rd.cnt : CNW'(k);
    lim   = {k, 1'b0};
    den   = (k == '0) ? CNW'(2) : {k, 1'b0};
    u1    = seen && (r > f_fs);
    fs_n  = u1 ? r : f_fs;
    nu_n  = (!seen && NU_W'(r) < f_nu) ? NU_W'(r) : f_nu;
    inb   = (r <= fs_n) && (NU_W'(r) >= nu_n);
    cnt_n = f_cnt;
    if (inb) begin
      if (seen && f_cnt < lim) begin
        cnt_n = f_cnt + CNW'(1);
      end else if (!seen && f_cnt != '0) begin
        cnt_n = f_cnt - CNW'(1);
      end
    end
    ma_pad = MAP_W'(ma);
    vres   = macc[ibo_pkg::VOL_SHIFT +: VW];
    nsum   = n + macc[ibo_pkg::N_W-1:0];
    dtrial = {drem[CNW-1:0], quo[DV_W-1]};
    nv_sum = (VW + 1)'(s1) + (VW + 1)'(quo[VW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_R2;
      pp_vld   <= 1'b0;
      m_tvalid <= 1'b0;
      k        <= ibo_pkg::K_RESET;
      w        <= ibo_pkg::AW_RESET;
      total    <= '0;
      ent_vld  <= '0;
      cnt_vld  <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          ibo_pkg::REG_CONF_STEPS: begin
            k       <= cfg_data[ibo_pkg::K_W-1:0];
            cnt_vld <= '0;
          end
          ibo_pkg::REG_AMB_WIDTH: w <= cfg_data[ibo_pkg::AW_W-1:0];
          default: ;
        endcase
      end
      // accumulate partial products, most significant chunk first
      if (pp_vld) begin
        macc <= (macc << 32) + MR_W'(pp);
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            opc   <= s_tuser;
            px    <= s_tdata[CW-1:0];
            py    <= s_tdata[2*CW-1:CW];
            pz    <= s_tdata[3*CW-1:2*CW];
            seen  <= s_tdata[3*CW];
            op    <= OP_R2;
            state <= ST_LOC;
          end
        end
        ST_LOC: begin
          // op doubles as the start marker: hold start for one cycle only
          op <= OP_R3;
          if (loc_stat.done) begin
            bin   <= loc_stat.bin;
            r     <= loc_r;
            ev    <= ent_vld[loc_stat.bin];
            cv    <= cnt_vld[loc_stat.bin];
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          qv    <= '0;
          fs_w  <= fs_n;
          nu_w  <= nu_n;
          cnt_w <= cnt_n;
          ovol  <= ev ? rd.vol : '0;
          if (opc) begin
            priority if (r > f_fs) begin
              state <= ST_FIN;
            end else if (NU_W'(r) < f_nu) begin
              qv    <= ibo_pkg::QV_FULL;
              state <= ST_FIN;
            end else begin
              cnt_w  <= f_cnt;
              ma     <= MA_W'(17'h10000 - 17'(w));
              mb     <= 32'((k == '0) ? 1 : int'(k));
              op     <= OP_N1;
              mc     <= MC_W'(NCH - 1);
              macc   <= '0;
              pp_vld <= 1'b0;
              state  <= ST_MUL;
            end
          end else if (u1 || inb || (!seen && nu_n != f_nu)) begin
            split  <= nu_n < NU_W'(fs_n);
            vph    <= !(nu_n < NU_W'(fs_n));
            ma     <= MA_W'((nu_n < NU_W'(fs_n)) ? CW'(nu_n) : fs_n);
            mb     <= 32'((nu_n < NU_W'(fs_n)) ? CW'(nu_n) : fs_n);
            op     <= OP_R2;
            mc     <= MC_W'(NCH - 1);
            macc   <= '0;
            pp_vld <= 1'b0;
            state  <= ST_MUL;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_MUL: begin
          pp     <= 64'(ma_pad[mc*32 +: 32]) * 64'(mb);
          pp_vld <= 1'b1;
          if (mc == '0) begin
            state <= ST_MULW;
          end else begin
            mc <= mc - MC_W'(1);
          end
        end
        ST_MULW: begin
          pp_vld <= 1'b0;
          state  <= ST_POST;
        end
        ST_POST: begin
          mc     <= MC_W'(NCH - 1);
          macc   <= '0;
          pp_vld <= 1'b0;
          state  <= ST_MUL;
          unique case (op)
            OP_R2: begin
              ma <= MA_W'(macc);
              op <= OP_R3;
            end
            OP_R3: begin
              ma <= MA_W'(macc);
              mb <= ibo_pkg::VOL_COEFF;
              op <= OP_V;
            end
            OP_V: begin
              if (!vph) begin
                s1  <= vres;
                vph <= 1'b1;
                ma  <= MA_W'(fs_w);
                mb  <= 32'(fs_w);
                op  <= OP_R2;
              end else begin
                vf <= vres;
                if (split) begin
                  ma <= MA_W'(17'h10000 - 17'(w));
                  mb <= 32'((k == '0) ? 1 : int'(k));
                  op <= OP_N1;
                end else begin
                  nv    <= ibo_pkg::VOL_W'(vres);
                  state <= ST_WB;
                end
              end
            end
            OP_N1: begin
              n  <= macc[ibo_pkg::N_W-1:0];
              ma <= MA_W'(w);
              mb <= 32'((k == '0) ? '0 : cnt_w);
              op <= OP_N2;
            end
            OP_N2: begin
              if (opc) begin
                quo   <= DV_W'(nsum);
                drem  <= '0;
                dc    <= DC_W'(DV_W);
                state <= ST_DIV;
              end else begin
                ma <= MA_W'(vf - s1);
                mb <= 32'(nsum);
                op <= OP_SN;
              end
            end
            OP_SN: begin
              quo   <= macc[ibo_pkg::FRAC_SHIFT +: DV_W];
              drem  <= '0;
              dc    <= DC_W'(DV_W);
              state <= ST_DIV;
            end
            default: state <= ST_FIN;
          endcase
        end
        ST_DIV: begin
          // restoring divide by 2k (by 2 when k is zero), one quotient bit per cycle
          if (dc == '0) begin
            if (opc) begin
              qv    <= ibo_pkg::QV_W'(quo);
              state <= ST_FIN;
            end else begin
              nv    <= ibo_pkg::VOL_W'(nv_sum);
              state <= ST_WB;
            end
          end else begin
            dc <= dc - DC_W'(1);
            if (dtrial >= (CNW + 1)'(den)) begin
              drem <= dtrial - (CNW + 1)'(den);
              quo  <= {quo[DV_W-2:0], 1'b1};
            end else begin
              drem <= dtrial;
              quo  <= {quo[DV_W-2:0], 1'b0};
            end
          end
        end
        ST_WB: begin
          ent_vld[bin] <= 1'b1;
          cnt_vld[bin] <= 1'b1;
          total <= total - ibo_pkg::TOT_W'(ovol) + ibo_pkg::TOT_W'(nv);
          state <= ST_FIN;
        end
        ST_FIN: begin
          // wait for the output register to free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ibo_pkg::M_W'({qv, total});
            op       <= OP_R2;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for icosahedral_boundary_observability_unit: random and directed
// update/query beats, config changes between phases, a bit-exact predictor in a scoreboard.
// Depends on ibo_pkg and the RTL top level.
`default_nettype none
module testbench;

  localparam int CW  = 16;
  localparam int SDW = ((3*CW+8)/8)*8;

  // Predicts results from a private copy of the bin memory and registers.
  class obs_scoreboard;
    logic [15:0] far_r [ibo_pkg::NUM_BINS];
    logic [16:0] near_r [ibo_pkg::NUM_BINS];
    logic [8:0]  amb [ibo_pkg::NUM_BINS];
    logic [29:0] vol [ibo_pkg::NUM_BINS];
    logic [33:0] total;
    logic [7:0]  k;
    logic [15:0] w;
    logic [33:0] exp_total [$];
    logic [16:0] exp_qv [$];
    int errors;

    function new();
      k = ibo_pkg::K_RESET;
      w = ibo_pkg::AW_RESET;
      total = '0;
      errors = 0;
      for (int i = 0; i < ibo_pkg::NUM_BINS; i++) begin
        far_r[i] = '0;
        near_r[i] = '1;
        amb[i] = {1'b0, ibo_pkg::K_RESET};
        vol[i] = '0;
      end
    endfunction

    function void write_reg(logic [ibo_pkg::CFG_IDX_W-1:0] idx,
                            logic [ibo_pkg::CFG_W-1:0] d);
      if (idx == ibo_pkg::REG_CONF_STEPS) begin
        k = d[7:0];
        for (int i = 0; i < ibo_pkg::NUM_BINS; i++) amb[i] = {1'b0, k};
      end else begin
        w = d;
      end
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint unsigned sphere(longint unsigned r);
      logic [127:0] p;
      p = 128'(r) * 128'(r) * 128'(r) * 128'(ibo_pkg::VOL_COEFF);
      return 64'(p >> 48);
    endfunction

    function void ratio(longint unsigned c, output longint unsigned num,
                        output longint unsigned den);
      if (k == 0) begin
        num = 65536 - longint'(w);
        den = 2;
      end else begin
        num = longint'(k) * (65536 - longint'(w)) + longint'(w) * c;
        den = 2 * longint'(k);
      end
    endfunction

    function int bin_of(longint x, longint y, longint z);
      longint d, best_d;
      int best;
      best = 0;
      best_d = 0;
      if (x == 0 && y == 0 && z == 0) return 0;
      for (int i = 0; i < ibo_pkg::NUM_BINS; i++) begin
        d = x * longint'(ibo_pkg::CENTRE[i][0]) + y * longint'(ibo_pkg::CENTRE[i][1])
          + z * longint'(ibo_pkg::CENTRE[i][2]);
        if (i == 0 || d > best_d) begin
          best_d = d;
          best = i;
        end
      end
      return best;
    endfunction

    // Advance the model by one accepted input beat and queue its result.
    function void note(logic op, logic [CW-1:0] px, logic [CW-1:0] py,
                       logic [CW-1:0] pz, logic seen);
      longint x, y, z;
      longint unsigned r, fs, nu, num, den, lim, s1, s2, nv;
      int b;
      logic touched;
      logic [16:0] qv;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      r = root(longint'(x*x) + longint'(y*y) + longint'(z*z));
      b = bin_of(x, y, z);
      qv = '0;
      if (op) begin
        if (r <= far_r[b]) begin
          if (r < near_r[b]) qv = ibo_pkg::QV_FULL;
          else begin
            ratio(amb[b], num, den);
            qv = 17'(num / den);
          end
        end
      end else begin
        touched = 1'b0;
        lim = 2 * longint'(k);
        if (seen) begin
          if (r > far_r[b]) begin far_r[b] = 16'(r); touched = 1'b1; end
        end else begin
          if (r < near_r[b]) begin near_r[b] = 17'(r); touched = 1'b1; end
        end
        if (r <= far_r[b] && r >= near_r[b]) begin
          if (seen) begin
            if (amb[b] < lim) amb[b] = amb[b] + 1;
          end else if (amb[b] > 0) begin
            amb[b] = amb[b] - 1;
          end
          touched = 1'b1;
        end
        if (touched) begin
          fs = far_r[b];
          nu = near_r[b];
          if (nu < fs) begin
            s1 = sphere(nu);
            s2 = sphere(fs) - s1;
            ratio(amb[b], num, den);
            nv = s1 + (s2 * num) / (den * 65536);
          end else begin
            nv = sphere(fs);
          end
          total = total - 34'(vol[b]) + 34'(nv[29:0]);
          vol[b] = nv[29:0];
        end
      end
      exp_total.push_back(total);
      exp_qv.push_back(qv);
    endfunction

    function void check(logic [ibo_pkg::M_W-1:0] d);
      logic [33:0] et;
      logic [16:0] eq;
      if (exp_total.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, d);
        return;
      end
      et = exp_total.pop_front();
      eq = exp_qv.pop_front();
      if (d[33:0] !== et) begin
        errors++;
        $display("%0t: total expected %0d actual %0d", $time, et, d[33:0]);
      end
      if (d[50:34] !== eq) begin
        errors++;
        $display("%0t: query expected %0d actual %0d", $time, eq, d[50:34]);
      end
    endfunction

    function int pending();
      return exp_total.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SDW-1:0] s_tdata = '0;   // pos_x, pos_y, pos_z, seen, zero fill
  logic s_tuser = 1'b0;           // opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ibo_pkg::M_W-1:0] m_tdata;   // total_observability, query_value, zero fill
  logic cfg_we = 1'b0;
  logic [ibo_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ibo_pkg::CFG_W-1:0] cfg_data = '0;

  obs_scoreboard sb = new();
  logic calm = 1'b0;       // no idling in the closing part
  logic hold_rx = 1'b0;    // request for one long receiver hold-off
  longint cycles = 0;

  icosahedral_boundary_observability_unit #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every output beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk);
    end
  end

  // Offer one beat and hold it until accepted; drop valid only for a gap.
  task automatic send(logic op, logic [CW-1:0] px, logic [CW-1:0] py,
                      logic [CW-1:0] pz, logic seen);
    int n;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(SDW-3*CW-1){1'b0}}, seen, pz, py, px};
    do @(posedge clk); while (!s_tready);
    sb.note(op, px, py, pz, seen);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
  endtask

  // Let everything drain, then settle before touching registers.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [ibo_pkg::CFG_IDX_W-1:0] idx,
                           logic [ibo_pkg::CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random coordinate; small magnitudes dominate so bins get reused.
  function automatic logic [CW-1:0] coord(int sc);
    logic [CW-1:0] v;
    v = CW'($urandom);
    if (sc < 15) v = CW'($signed(v) >>> (15 - sc));
    return v;
  endfunction

  task automatic random_run(int count);
    logic [CW-1:0] x, y, z;
    int sc;
    x = '0; y = '0; z = '0;
    for (int i = 0; i < count; i++) begin
      sc = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(4, 11);
      if ($urandom_range(0, 2) != 0 || i == 0) begin
        x = coord(sc); y = coord(sc); z = coord(sc);
      end else begin
        // revisit the last viewpoint: halved along the same ray, nudged in x and y, or repeated
        case ($urandom_range(0, 2))
          0: begin x = CW'($signed(x) >>> 1); y = CW'($signed(y) >>> 1);
                   z = CW'($signed(z) >>> 1); end
          1: begin x = x + CW'($urandom_range(0, 3)); y = y + CW'($urandom_range(0, 3)); end
          default: ;
        endcase
      end
      send($urandom_range(0, 2) == 0, x, y, z, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero position, extremes, both opcodes, seen both ways
    send(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send(1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send(1'b0, 16'h4000, 16'h4000, 16'h4000, 1'b0);
    send(1'b1, 16'h4000, 16'h4000, 16'h4000, 1'b0);
    send(1'b1, 16'h2000, 16'h2000, 16'h2000, 1'b0);
    send(1'b0, 16'h0100, 16'h0000, 16'h0000, 1'b1);
    send(1'b0, 16'h0000, 16'h0100, 16'h0000, 1'b0);
    send(1'b0, 16'h0000, 16'h0000, 16'hff00, 1'b1);
    send(1'b0, 16'h0001, 16'h0000, 16'h0000, 1'b1);
    // equal dot products on opposite axes: lowest index must win
    send(1'b1, 16'h0000, 16'h0000, 16'h0001, 1'b1);
    send(1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    send(1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send(1'b1, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    drain();

    // zero k: counters pinned at zero, low band edge
    write_cfg(ibo_pkg::REG_CONF_STEPS, 16'h0000);
    write_cfg(ibo_pkg::REG_AMB_WIDTH, 16'h0000);
    send(1'b0, 16'h4000, 16'h4000, 16'h4000, 1'b0);
    send(1'b0, 16'h4000, 16'h4000, 16'h4000, 1'b1);
    send(1'b1, 16'h4000, 16'h4000, 16'h4000, 1'b0);
    random_run(120);
    drain();

    // widest settings; block fills while the receiver holds off
    write_cfg(ibo_pkg::REG_CONF_STEPS, 16'h00ff);
    write_cfg(ibo_pkg::REG_AMB_WIDTH, 16'hffff);
    hold_rx = 1'b1;
    random_run(180);
    drain();

    write_cfg(ibo_pkg::REG_CONF_STEPS, 16'h0001);
    write_cfg(ibo_pkg::REG_AMB_WIDTH, 16'h0001);
    random_run(180);
    drain();

    write_cfg(ibo_pkg::REG_CONF_STEPS, 16'hff03);
    write_cfg(ibo_pkg::REG_AMB_WIDTH, 16'h5a5a);
    random_run(150);
    drain();

    calm = 1'b1;
    random_run(100);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
